FILE: design/tksi_pkg.sv
// shared constants and types for the top-k sorted insertion block
package tksi_pkg;

    localparam int CAPACITY   = 10;
    localparam int TAG_BITS   = 32;
    localparam int SCORE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int FIELD_W    = 4;
    localparam int OUT_TAG_W  = 32;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 80;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } tksi_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } tksi_cmd_t;

    typedef struct packed {
        logic                          accepted;
        logic [FIELD_W-1:0]            rank;
        logic [FIELD_W-1:0]            entry_count;
        logic                          evicted;
        logic signed [SCORE_BITS-1:0]  evicted_score;
        logic [OUT_TAG_W-1:0]          evicted_tag;
    } tksi_result_t;

endpackage

FILE: design/tksi_ctrl.sv
// controller: accepts one word, runs the insert step, holds the output valid
module tksi_ctrl
    import tksi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output tksi_cmd_t cmd
);

    tksi_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // output slot empty, or its word leaves at this same edge
                s_tready    = !out_valid_reg || m_tready;
                cmd.load_in = s_tvalid && s_tready;
                if (cmd.load_in) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: design/tksi_datapath.sv
// datapath: held list, parallel compare, combinational shift insert, result register
module tksi_datapath
    import tksi_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tksi_cmd_t                    cmd,
    input  logic signed [SCORE_BITS-1:0] in_score,
    input  logic [TAG_BITS-1:0]          in_tag,
    output tksi_result_t                 result
);

    logic signed [SCORE_BITS-1:0] score_in_reg;
    logic [TAG_BITS-1:0]          tag_in_reg;
    logic signed [SCORE_BITS-1:0] held_score_reg [CAPACITY];
    logic [TAG_BITS-1:0]          held_tag_reg   [CAPACITY];
    logic signed [SCORE_BITS-1:0] held_score_next [CAPACITY];
    logic [TAG_BITS-1:0]          held_tag_next   [CAPACITY];
    logic [CNT_W-1:0]             count_reg, count_next;
    tksi_result_t                 result_reg, result_next;

    logic             full, evict, place;
    logic [CNT_W-1:0] n_eff, pos;
    logic [CAPACITY-1:0] ge, prev_ge;

    // eviction check, and entries at or above the new score, a prefix since the list is sorted
    always_comb begin
        full  = (count_reg == CNT_W'(CAPACITY));
        evict = full && (held_score_reg[CAPACITY-1] < score_in_reg);
        place = !full || evict;
        n_eff = evict ? CNT_W'(CAPACITY - 1) : count_reg;
        pos   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CNT_W'(i) < n_eff) && (held_score_reg[i] >= score_in_reg);
            if (ge[i]) begin
                pos = CNT_W'(i + 1);
            end
        end
        prev_ge[0] = 1'b1;
        for (int i = 1; i < CAPACITY; i++) begin
            prev_ge[i] = ge[i-1];
        end
    end

    // keep above the slot, drop new word in, shift the rest down by one
    always_comb begin
        held_score_next[0] = ge[0] ? held_score_reg[0] : score_in_reg;
        held_tag_next[0]   = ge[0] ? held_tag_reg[0]   : tag_in_reg;
        for (int i = 1; i < CAPACITY; i++) begin
            if (ge[i]) begin
                held_score_next[i] = held_score_reg[i];
                held_tag_next[i]   = held_tag_reg[i];
            end else if (prev_ge[i]) begin
                held_score_next[i] = score_in_reg;
                held_tag_next[i]   = tag_in_reg;
            end else begin
                held_score_next[i] = held_score_reg[i-1];
                held_tag_next[i]   = held_tag_reg[i-1];
            end
        end
        count_next = place ? (n_eff + CNT_W'(1)) : count_reg;
    end

    always_comb begin
        result_next.accepted      = place;
        result_next.rank          = place ? FIELD_W'(pos) : '0;
        result_next.entry_count   = FIELD_W'(count_next);
        result_next.evicted       = evict;
        result_next.evicted_score = evict ? held_score_reg[CAPACITY-1] : '0;
        result_next.evicted_tag   = evict ? OUT_TAG_W'(held_tag_reg[CAPACITY-1]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            score_in_reg <= in_score;
            tag_in_reg   <= in_tag;
        end
        if (cmd.exec) begin
            result_reg <= result_next;
            if (place) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    held_score_reg[i] <= held_score_next[i];
                    held_tag_reg[i]   <= held_tag_next[i];
                end
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: design/top_k_sorted_insert.sv
// top level of the top-k sorted insertion list
//
// keeps the CAPACITY best entries (score, tag) in descending score order.
// input stream s_*: one word per offered entry, score and tag in s_tdata.
// output stream m_*: one word per input word with accepted, rank, count
// after the step and the evicted entry, if any (zeros when none).
// a full list rejects an entry that does not beat the lowest held score;
// otherwise the lowest entry is evicted. ties go behind equal scores.
// timing: a word is taken into the input registers and the compare/shift
// step runs in the execute state; m_tvalid rises as the result register
// is written at the end of that step, and the word then waits for m_tready.
// a new word is not taken while a step is pending; the controller's
// load/execute sequence holds s_tready low around the compare and shift.
// the result sits in an output register; a new input is taken only while
// that register is empty or its word leaves at the same edge, so a
// stalled m_tready holds back s_tready and no word is lost.
// reset (aresetn low, synchronous) empties the list and drops m_tvalid;
// held entries are not cleared, only entries below the count are ever read.
module top_k_sorted_insert
    import tksi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // score[31:0], entry_tag[63:32]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // accepted[0], rank[4:1], entry_count[8:5],
                                           // evicted[9], evicted_score[41:10],
                                           // evicted_tag[73:42], zero pad[79:74]
);

    tksi_cmd_t    cmd;
    tksi_result_t result;

    // control: handshakes and step sequencing
    tksi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // list storage and insert logic; tag keeps its low TAG_BITS bits
    tksi_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_score (s_tdata[SCORE_BITS-1:0]),
        .in_tag   (TAG_BITS'(s_tdata[S_DATA_W-1:SCORE_BITS])),
        .result   (result)
    );

    // pack the result word, lowest field first
    assign m_tdata = {6'b0,
                      result.evicted_tag,
                      result.evicted_score,
                      result.evicted,
                      result.entry_count,
                      result.rank,
                      result.accepted};

    // one word at a time: no second input while a step is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a step is pending");

    // every accepted input word has m_tvalid high once its execute step is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result missing after input word");

    // a rejected entry leaves no eviction and rank zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (!m_tdata[9] && (m_tdata[4:1] == 4'd0)))
        else $error("rejected entry reports eviction or rank");

    // count never passes the list capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] <= FIELD_W'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

FILE: sim/top_k_sorted_insert_tb.sv
// testbench for top_k_sorted_insert: directed and random entries against a list predictor
`timescale 1ns / 1ps

module top_k_sorted_insert_tb;
    import tksi_pkg::*;

    // generous ceiling on cycles, far above the slowest correct run
    localparam int CYCLE_LIMIT = 400000;
    // cycles the block may still be busy after its last word
    localparam int SETTLE_CYCLES = 8;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // score[31:0], entry_tag[63:32]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // accepted[0], rank[4:1], entry_count[8:5],
                                          // evicted[9], evicted_score[41:10],
                                          // evicted_tag[73:42], zero pad[79:74]

    // predicted contents of the list, descending by score
    logic signed [SCORE_BITS-1:0] list_scores [CAPACITY];
    logic [TAG_BITS-1:0]          list_tags   [CAPACITY];
    int                           list_count = 0;

    // outcomes still owed by the block, oldest first
    tksi_result_t pending_outcomes [$];

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  sink_stall   = 0;
    bit  source_gaps  = 1'b0;
    bit  sink_gaps    = 1'b0;

    top_k_sorted_insert dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** top_k_sorted_insert: FAILED **");
            $finish;
        end
    end

    // idle length: mostly none, often short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // work out what offering (score, tag) does to the list and what the block reports
    function automatic tksi_result_t place_entry(logic signed [SCORE_BITS-1:0] score,
                                                 logic [TAG_BITS-1:0] tag);
        tksi_result_t outcome;
        int n;
        int pos;
        outcome = '0;
        n = list_count;
        // full list: only a score strictly above the lowest one gets in
        if (n == CAPACITY && list_scores[CAPACITY-1] < score) begin
            outcome.evicted       = 1'b1;
            outcome.evicted_score = list_scores[CAPACITY-1];
            outcome.evicted_tag   = list_tags[CAPACITY-1];
            n = CAPACITY - 1;
        end
        if (n < CAPACITY) begin
            // ties go behind held entries of the same score
            pos = 0;
            while (pos < n && list_scores[pos] >= score)
                pos++;
            for (int i = n; i > pos; i--) begin
                list_scores[i] = list_scores[i-1];
                list_tags[i]   = list_tags[i-1];
            end
            list_scores[pos] = score;
            list_tags[pos]   = tag;
            n++;
            outcome.accepted = 1'b1;
            outcome.rank     = FIELD_W'(pos);
        end
        list_count = n;
        outcome.entry_count = FIELD_W'(n);
        return outcome;
    endfunction

    // offer one word; called and returning at a falling edge
    task automatic send_entry(input logic signed [SCORE_BITS-1:0] score,
                              input logic [TAG_BITS-1:0] tag);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, score};
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(place_entry(score, tag));
        @(negedge aclk);
    endtask

    // stop offering and let every owed word come back
    task automatic wait_for_outcomes();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // sink side: random back-pressure when enabled
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready   <= 1'b1;
            sink_stall <= sink_gaps ? pick_gap() : 0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // compare every returned word with the oldest outcome owed
    always @(posedge aclk) begin : outcome_check
        tksi_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %0h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("accepted",      32'(want.accepted),    32'(m_tdata[0]));
                check_field("rank",          32'(want.rank),        32'(m_tdata[4:1]));
                check_field("entry_count",   32'(want.entry_count), 32'(m_tdata[8:5]));
                check_field("evicted",       32'(want.evicted),     32'(m_tdata[9]));
                check_field("evicted_score", want.evicted_score,    m_tdata[41:10]);
                check_field("evicted_tag",   want.evicted_tag,      m_tdata[73:42]);
            end
        end
    end

    // score choice that keeps the full list busy: near the lowest held score,
    // a narrow band full of ties, the extremes, or anything at all
    function automatic logic signed [SCORE_BITS-1:0] pick_score();
        logic signed [SCORE_BITS-1:0] lowest;
        int r;
        lowest = (list_count == 0) ? '0 : list_scores[list_count-1];
        r = $urandom_range(0, 9);
        if (r < 3) return lowest + $signed(32'($urandom_range(0, 2))) - 1;
        if (r < 5) return $signed(32'($urandom_range(0, 16))) - 8;
        if (r == 5) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    // fill from empty with extremes and ties, then reject, evict, reject and evict again
    task automatic test_fill_ties_and_evictions();
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        send_entry(32'sh00000000, 32'h00000000);
        send_entry(32'sh7fffffff, 32'hffffffff);
        send_entry(32'sh80000000, 32'h00000001);
        send_entry(32'sh00000000, 32'h00000002);   // tie behind the held zero
        send_entry(-32'sd1,       32'h00000003);
        send_entry(32'sh7fffffff, 32'h00000004);   // tie at the top
        send_entry(32'sh00000001, 32'h00000005);
        send_entry(32'sh80000000, 32'h00000006);   // tie at the bottom
        send_entry(32'sh00000064, 32'h00000007);
        send_entry(-32'sd100,     32'haaaaaaaa);   // list now full
        send_entry(32'sh80000000, 32'h55555555);   // equal to lowest: rejected
        send_entry(32'sh80000001, 32'h00000008);   // evicts the newer minimum
        send_entry(-32'sd5000,    32'h00000009);
        send_entry(32'sh7fffffff, 32'h0000000a);   // lands behind both maxima
        send_entry(32'sh80000000, 32'h0000000b);   // below lowest: rejected
        send_entry(list_scores[CAPACITY-1], 32'h0000000c);
        send_entry(list_scores[CAPACITY-1] + 1, 32'h0000000d);
        wait_for_outcomes();
    endtask

    task automatic test_random_offers(input int count);
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        repeat (count) send_entry(pick_score(), $urandom);
    endtask

    // sender holds off until the block has answered everything
    task automatic test_pause_until_drained();
        wait_for_outcomes();
        test_random_offers(20);
        wait_for_outcomes();
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int count);
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        repeat (count) send_entry(pick_score(), $urandom);
        wait_for_outcomes();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_fill_ties_and_evictions();
        test_random_offers(200);
        test_pause_until_drained();
        test_back_to_back(60);
        test_random_offers(200);
        wait_for_outcomes();

        if (error_count == 0) begin
            $display("** top_k_sorted_insert: PASSED **");
        end else begin
            $display("** top_k_sorted_insert: FAILED **");
        end
        $finish;
    end

endmodule

FILE: top_k_sorted_insert.f
design/tksi_pkg.sv
design/tksi_ctrl.sv
design/tksi_datapath.sv
design/top_k_sorted_insert.sv
sim/top_k_sorted_insert_tb.sv
